// File: hw/rtl/ofip_pkg.sv
`default_nettype none

package ofip_pkg;

   // character codes the parser looks for
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // input item
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_line;
   } req_type;

   // result item
   typedef struct packed {
      logic        [15:0] triangle_number;
      logic        [30:0] vertex_a;
      logic signed [31:0] normal_a;
      logic        [30:0] vertex_b;
      logic signed [31:0] normal_b;
      logic        [30:0] vertex_c;
      logic signed [31:0] normal_c;
   } rsp_type;

   // classified character as carried through the queue
   typedef struct packed {
      logic       is_f;
      logic       is_slash;
      logic       is_space;
      logic       is_blank;
      logic       is_digit;
      logic       is_plus;
      logic       is_minus;
      logic [3:0] digit;
      logic       end_of_line;
   } chr_class_type;

   // front write port into the queue
   typedef struct packed {
      logic          push;
      chr_class_type data;
   } q_wr_type;

endpackage

`default_nettype wire

// File: hw/rtl/ofip_front.sv
`default_nettype none

module ofip_front
   import ofip_pkg::*;
(
   input  wire            req_valid,
   input  req_type        req_data,
   output logic           req_stall,
   input  wire            q_full,
   output q_wr_type       q_wr
);

   logic [7:0] ch;
   logic [7:0] digit_off;

   assign ch        = req_data.ch;
   assign digit_off = ch - CHAR_ZERO;

   // take an item whenever the queue has room
   assign req_stall   = q_full;
   assign q_wr.push   = req_valid && !q_full;

   // character classification
   always_comb begin
      q_wr.data.is_f        = (ch == CHAR_F);
      q_wr.data.is_slash    = (ch == CHAR_SLASH);
      q_wr.data.is_space    = (ch == CHAR_SPACE);
      q_wr.data.is_blank    = (ch == CHAR_SPACE) || (ch >= CHAR_TAB && ch <= CHAR_CR);
      q_wr.data.is_digit    = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      q_wr.data.is_plus     = (ch == CHAR_PLUS);
      q_wr.data.is_minus    = (ch == CHAR_MINUS);
      q_wr.data.digit       = digit_off[3:0];
      q_wr.data.end_of_line = req_data.end_of_line;
   end

endmodule

`default_nettype wire

// File: hw/rtl/ofip_queue.sv
`default_nettype none

module ofip_queue
   import ofip_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  q_wr_type      q_wr,
   input  wire           q_pop,
   output logic          q_valid,
   output chr_class_type q_data,
   output logic          q_full
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   chr_class_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign q_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = q_wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (q_wr.push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_wr.push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ofip_back.sv
`default_nettype none

module ofip_back
   import ofip_pkg::*;
#(
   parameter int INDEX_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           q_valid,
   input  chr_class_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  wire           rsp_stall
);

   localparam int VW = INDEX_BITS - 1;
   localparam int NW = INDEX_BITS;
   localparam int AW = INDEX_BITS + 3;
   localparam logic [AW-1:0] NCAP = AW'(1) << (INDEX_BITS - 1);
   localparam logic [AW-1:0] VCAP = NCAP - AW'(1);

   // main scan phases
   localparam logic [2:0] PH_SEEK_F     = 3'd0;
   localparam logic [2:0] PH_SEEK_DIGIT = 3'd1;
   localparam logic [2:0] PH_VDIGITS    = 3'd2;
   localparam logic [2:0] PH_LOOP1      = 3'd3;
   localparam logic [2:0] PH_LOOP2      = 3'd4;
   localparam logic [2:0] PH_SEEK_SPACE = 3'd5;
   localparam logic [2:0] PH_DONE       = 3'd6;

   // lookahead phases
   localparam logic [1:0] LA_IDLE   = 2'd0;
   localparam logic [1:0] LA_SPACE  = 2'd1;
   localparam logic [1:0] LA_DIGITS = 2'd2;

   logic [2:0]            phase_ff, phase_in;
   logic [1:0]            blk_ff, blk_in;
   logic [VW-1:0]         vacc_ff, vacc_in;
   logic [NW-1:0]         nacc_ff, nacc_in;
   logic [1:0]            la_ff, la_in;
   logic                  neg_ff, neg_in;
   logic [1:0]            target_ff, target_in;
   logic [VW-1:0]         vert_ff [3];
   logic [VW-1:0]         vert_in [3];
   logic [31:0]           norm_ff [3];
   logic [31:0]           norm_in [3];
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [AW-1:0]         vsum;
   logic [AW-1:0]         nsum;
   logic [AW-1:0]         npos;
   logic [31:0]           norm_val;
   logic                  la_put;
   logic [1:0]            target_slot;
   logic [31:0]           cnt_wide;

   // multiply by ten, add a digit, clamp
   function automatic logic [AW-1:0] add_digit(input logic [AW-1:0] acc,
                                               input logic [3:0]    d,
                                               input logic [AW-1:0] cap);
      logic [AW-1:0] sum;
      sum = (acc << 3) + (acc << 1) + AW'(d);
      return (sum > cap) ? cap : sum;
   endfunction

   assign q_pop     = q_valid && !(rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shared digit adders
   always_comb begin
      vsum = add_digit((phase_ff == PH_SEEK_DIGIT) ? '0 : AW'(vacc_ff),
                       q_data.digit, VCAP);
      nsum = add_digit(AW'(nacc_ff), q_data.digit, NCAP);
      npos = (nsum > VCAP) ? VCAP : nsum;
      norm_val = neg_ff ? (32'd0 - 32'(nsum[NW-1:0])) : 32'(npos[VW-1:0]);
      target_slot = (target_ff == 2'd3) ? 2'd0 : target_ff;
      cnt_wide = 32'(cnt_ff);
   end

   // next state for one character
   always_comb begin
      phase_in     = phase_ff;
      blk_in       = blk_ff;
      vacc_in      = vacc_ff;
      nacc_in      = nacc_ff;
      la_in        = la_ff;
      neg_in       = neg_ff;
      target_in    = target_ff;
      vert_in      = vert_ff;
      norm_in      = norm_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      la_put       = 1'b0;

      // normal lookahead, atoi rules
      unique case (la_ff)
         LA_SPACE: begin
            if (q_data.is_blank) begin
               la_in = LA_SPACE;
            end else if (q_data.is_plus || q_data.is_minus) begin
               neg_in = q_data.is_minus;
               la_in  = LA_DIGITS;
            end else if (q_data.is_digit) begin
               la_in   = LA_DIGITS;
               nacc_in = nsum[NW-1:0];
               la_put  = 1'b1;
            end else begin
               la_in = LA_IDLE;
            end
         end
         LA_DIGITS: begin
            if (q_data.is_digit) begin
               nacc_in = nsum[NW-1:0];
               la_put  = 1'b1;
            end else begin
               la_in = LA_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (la_put) begin
         for (int k = 0; k < 3; k++) begin
            if (target_slot == 2'(k)) begin
               norm_in[k] = norm_val;
            end
         end
      end

      // main scan
      unique case (phase_ff) inside
         PH_SEEK_F: begin
            if (q_data.is_f) begin
               phase_in = PH_SEEK_DIGIT;
            end
         end
         PH_SEEK_DIGIT, PH_VDIGITS, PH_LOOP1: begin
            if (q_data.is_digit && phase_ff != PH_LOOP1) begin
               vacc_in  = vsum[VW-1:0];
               phase_in = PH_VDIGITS;
               for (int k = 0; k < 3; k++) begin
                  if (blk_ff == 2'(k)) begin
                     vert_in[k] = vsum[VW-1:0];
                  end
               end
            end else if (phase_ff != PH_SEEK_DIGIT) begin
               // first slash search, entered directly from the vertex digits
               phase_in = PH_LOOP1;
               if (q_data.is_slash) begin
                  phase_in = PH_LOOP2;
               end else if (q_data.is_space) begin
                  if (blk_ff >= 2'd2) begin
                     phase_in = PH_DONE;
                  end else begin
                     blk_in   = blk_ff + 2'd1;
                     phase_in = PH_SEEK_DIGIT;
                  end
               end
            end
         end
         PH_LOOP2: begin
            if (q_data.is_slash) begin
               nacc_in   = '0;
               neg_in    = 1'b0;
               target_in = blk_ff;
               la_in     = LA_SPACE;
               if (blk_ff >= 2'd2) begin
                  phase_in = PH_DONE;
               end else begin
                  blk_in   = blk_ff + 2'd1;
                  phase_in = PH_SEEK_SPACE;
               end
            end else if (q_data.is_space) begin
               if (blk_ff >= 2'd2) begin
                  phase_in = PH_DONE;
               end else begin
                  blk_in   = blk_ff + 2'd1;
                  phase_in = PH_SEEK_DIGIT;
               end
            end
         end
         PH_SEEK_SPACE: begin
            if (q_data.is_space) begin
               phase_in = PH_SEEK_DIGIT;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // end of line: emit the record and clear the line state
      if (q_data.end_of_line) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.triangle_number = cnt_wide[15:0];
         rsp_data_in.vertex_a        = 31'(vert_in[0]);
         rsp_data_in.normal_a        = norm_in[0];
         rsp_data_in.vertex_b        = 31'(vert_in[1]);
         rsp_data_in.normal_b        = norm_in[1];
         rsp_data_in.vertex_c        = 31'(vert_in[2]);
         rsp_data_in.normal_c        = norm_in[2];
         cnt_in    = cnt_ff + 1'b1;
         phase_in  = PH_SEEK_F;
         blk_in    = '0;
         vacc_in   = '0;
         nacc_in   = '0;
         la_in     = LA_IDLE;
         neg_in    = 1'b0;
         target_in = '0;
         for (int k = 0; k < 3; k++) begin
            vert_in[k] = '0;
            norm_in[k] = '0;
         end
      end
   end

   // parser state, advanced once per item taken from the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEEK_F;
         blk_ff    <= '0;
         vacc_ff   <= '0;
         nacc_ff   <= '0;
         la_ff     <= LA_IDLE;
         neg_ff    <= 1'b0;
         target_ff <= '0;
         cnt_ff    <= '0;
         for (int k = 0; k < 3; k++) begin
            vert_ff[k] <= '0;
            norm_ff[k] <= '0;
         end
      end else if (q_pop) begin
         phase_ff  <= phase_in;
         blk_ff    <= blk_in;
         vacc_ff   <= vacc_in;
         nacc_ff   <= nacc_in;
         la_ff     <= la_in;
         neg_ff    <= neg_in;
         target_ff <= target_in;
         cnt_ff    <= cnt_in;
         vert_ff   <= vert_in;
         norm_ff   <= norm_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= rsp_valid_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/obj_face_index_parser_top.sv
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_data  (ch, end_of_line)
// rsp       out        rsp_valid / rsp_stall  rsp_data  (triangle_number, vertices, normals)
//
// one character per cycle sustained while the receiver does not stall; the character
// that ends a line is held in a queue entry, then its record in the output register
// the front classifies characters into a two-entry queue; the back pops one
// entry per cycle and only holds while a finished record sits stalled
// reset is synchronous and clears the queue, the parser and the line counter

module obj_face_index_parser_top
   import ofip_pkg::*;
#(
   parameter int INDEX_BITS = 32,
   parameter int COUNT_BITS = 16
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  wire     rsp_stall
);

   q_wr_type      q_wr;
   logic          q_full;
   logic          q_valid;
   logic          q_pop;
   chr_class_type q_data;

   // character classification
   ofip_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_wr      (q_wr)
   );

   // decoupling queue
   ofip_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_wr    (q_wr),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_full  (q_full)
   );

   // face parser and record output
   ofip_back #(
      .INDEX_BITS (INDEX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// File: verif/tb_obj_face_index_parser_checker.sv
module tb_obj_face_index_parser_checker
   import ofip_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  req_type req_data,
   input  wire     req_stall,
   input  wire     rsp_valid,
   input  rsp_type rsp_data,
   input  wire     rsp_stall,
   output int      fail_count,
   output int      records_pending
);

   localparam logic [63:0] POSITIVE_MAX = 64'h7FFF_FFFF;
   localparam logic [63:0] NORMAL_CAP   = 64'h8000_0000;

   typedef enum logic [2:0] {
      SCAN_SEEK_F,
      SCAN_SEEK_DIGIT,
      SCAN_VERTEX,
      SCAN_FIRST_SLASH,
      SCAN_SECOND_SLASH,
      SCAN_SEEK_SPACE,
      SCAN_DONE
   } scan_state_type;

   typedef enum logic [1:0] {
      NORM_IDLE,
      NORM_BLANKS,
      NORM_DIGITS
   } norm_state_type;

   // per-line parser state
   scan_state_type scan_state;
   norm_state_type norm_state;
   logic [1:0]     block_idx;
   logic [1:0]     norm_slot;
   logic [63:0]    vertex_acc;
   logic [63:0]    normal_acc;
   logic           normal_neg;
   logic [30:0]    vertex_field [3];
   logic [31:0]    normal_field [3];
   logic [15:0]    line_count;

   rsp_type expected_records [$];
   int      errors = 0;

   function automatic logic char_is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic char_is_blank(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // decimal accumulate with saturation at cap
   function automatic logic [63:0] add_decimal(logic [63:0] acc, logic [7:0] c,
                                               logic [63:0] cap);
      logic [63:0] sum;
      sum = acc * 64'd10 + 64'(c - CHAR_ZERO);
      return (sum > cap) ? cap : sum;
   endfunction

   function automatic void clear_line();
      int k;
      scan_state = SCAN_SEEK_F;
      norm_state = NORM_IDLE;
      block_idx  = '0;
      norm_slot  = '0;
      vertex_acc = '0;
      normal_acc = '0;
      normal_neg = 1'b0;
      for (k = 0; k < 3; k++) begin
         vertex_field[k] = '0;
         normal_field[k] = '0;
      end
   endfunction

   function automatic void store_normal();
      if (normal_neg) begin
         normal_field[norm_slot] = 32'd0 - normal_acc[31:0];
      end else begin
         normal_field[norm_slot] = (normal_acc > POSITIVE_MAX) ? POSITIVE_MAX[31:0]
                                                               : normal_acc[31:0];
      end
   endfunction

   function automatic void end_block(scan_state_type next_state);
      if (block_idx >= 2'd2) begin
         scan_state = SCAN_DONE;
      end else begin
         block_idx++;
         scan_state = next_state;
      end
   endfunction

   // normal reader, runs ahead of the main scan on the same character
   function automatic void step_normal(logic [7:0] c);
      case (norm_state)
         NORM_BLANKS: begin
            if (!char_is_blank(c)) begin
               if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  normal_neg = (c == CHAR_MINUS);
                  norm_state = NORM_DIGITS;
               end else if (char_is_digit(c)) begin
                  norm_state = NORM_DIGITS;
                  normal_acc = add_decimal(normal_acc, c, NORMAL_CAP);
                  store_normal();
               end else begin
                  norm_state = NORM_IDLE;
               end
            end
         end
         NORM_DIGITS: begin
            if (char_is_digit(c)) begin
               normal_acc = add_decimal(normal_acc, c, NORMAL_CAP);
               store_normal();
            end else begin
               norm_state = NORM_IDLE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void first_slash(logic [7:0] c);
      if (c == CHAR_SLASH) begin
         scan_state = SCAN_SECOND_SLASH;
      end else if (c == CHAR_SPACE) begin
         end_block(SCAN_SEEK_DIGIT);
      end
   endfunction

   // main scan over f, vertex digits and slashes
   function automatic void step_scan(logic [7:0] c);
      case (scan_state)
         SCAN_SEEK_F: begin
            if (c == CHAR_F) scan_state = SCAN_SEEK_DIGIT;
         end
         SCAN_SEEK_DIGIT: begin
            if (char_is_digit(c)) begin
               vertex_acc = add_decimal(64'd0, c, POSITIVE_MAX);
               vertex_field[block_idx] = vertex_acc[30:0];
               scan_state = SCAN_VERTEX;
            end
         end
         SCAN_VERTEX: begin
            if (char_is_digit(c)) begin
               vertex_acc = add_decimal(vertex_acc, c, POSITIVE_MAX);
               vertex_field[block_idx] = vertex_acc[30:0];
            end else begin
               // the ending character already takes part in the slash search
               scan_state = SCAN_FIRST_SLASH;
               first_slash(c);
            end
         end
         SCAN_FIRST_SLASH: begin
            first_slash(c);
         end
         SCAN_SECOND_SLASH: begin
            if (c == CHAR_SLASH) begin
               normal_acc = '0;
               normal_neg = 1'b0;
               norm_slot  = block_idx;
               norm_state = NORM_BLANKS;
               end_block(SCAN_SEEK_SPACE);
            end else if (c == CHAR_SPACE) begin
               end_block(SCAN_SEEK_DIGIT);
            end
         end
         SCAN_SEEK_SPACE: begin
            if (c == CHAR_SPACE) scan_state = SCAN_SEEK_DIGIT;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d (0x%08h), got %0d (0x%08h)",
                  $time, name, want, want, got, got);
         return 1;
      end
      return 0;
   endfunction

   function automatic int record_diff(rsp_type want, rsp_type got);
      int n;
      n = field_diff("triangle_number", want.triangle_number, got.triangle_number);
      n += field_diff("vertex_a", want.vertex_a, got.vertex_a);
      n += field_diff("normal_a", want.normal_a, got.normal_a);
      n += field_diff("vertex_b", want.vertex_b, got.vertex_b);
      n += field_diff("normal_b", want.normal_b, got.normal_b);
      n += field_diff("vertex_c", want.vertex_c, got.vertex_c);
      n += field_diff("normal_c", want.normal_c, got.normal_c);
      return n;
   endfunction

   // predict on each accepted item, compare each accepted record
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_line();
         line_count = '0;
         expected_records.delete();
      end else begin
         if (req_valid && !req_stall) begin
            step_normal(req_data.ch);
            step_scan(req_data.ch);
            if (req_data.end_of_line) begin
               want.triangle_number = line_count;
               want.vertex_a        = vertex_field[0];
               want.normal_a        = normal_field[0];
               want.vertex_b        = vertex_field[1];
               want.normal_b        = normal_field[1];
               want.vertex_c        = vertex_field[2];
               want.normal_c        = normal_field[2];
               expected_records.push_back(want);
               line_count++;
               clear_line();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               $display("%0t: record with none expected, got 0x%h", $time, rsp_data);
               errors++;
            end else if (record_diff(expected_records[0], rsp_data) != 0) begin
               errors++;
               void'(expected_records.pop_front());
            end else begin
               void'(expected_records.pop_front());
            end
         end
      end
      fail_count      <= errors;
      records_pending <= expected_records.size();
   end

endmodule

// File: verif/tb_obj_face_index_parser_top.sv
module tb_obj_face_index_parser_top;
   import ofip_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_HALF,
      RX_LIGHT,
      RX_HEAVY
   } stall_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;
   int      fail_count;
   int      records_pending;

   int         accepted_items = 0;
   int         burst_left = 0;
   int         cycle_count = 0;
   logic [7:0] text_q [$];

   obj_face_index_parser_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   tb_obj_face_index_parser_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_data        (req_data),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .rsp_stall       (rsp_stall),
      .fail_count      (fail_count),
      .records_pending (records_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // line text builders
   function automatic void add_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic void add_digits(int n);
      int i;
      for (i = 0; i < n; i++) text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_number();
      case ($urandom_range(0, 19))
         0: add_digits($urandom_range(10, 13));
         1: begin
            case ($urandom_range(0, 2))
               0: add_text("2147483647");
               1: add_text("2147483648");
               default: add_text("2147483649");
            endcase
         end
         default: add_digits($urandom_range(1, 4));
      endcase
   endfunction

   function automatic void add_blanks();
      int i;
      int n;
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0) text_q.push_back(CHAR_SPACE);
         else text_q.push_back(8'($urandom_range(CHAR_TAB, CHAR_CR)));
      end
   endfunction

   // normal text after the second slash: blanks or garbage, sign, digits
   function automatic void add_normal_text();
      case ($urandom_range(0, 9))
         7: add_blanks();
         8: text_q.push_back(8'($urandom_range(0, 255)));
         default: begin
         end
      endcase
      if ($urandom_range(0, 2) == 0) begin
         text_q.push_back(($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_MINUS);
      end
      if ($urandom_range(0, 19) != 0) add_number();
   endfunction

   function automatic void build_face_line();
      int i;
      int n;
      int blocks;
      text_q.delete();
      if ($urandom_range(0, 19) == 0) begin
         // pure noise line
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 9) == 0) add_blanks();
         if ($urandom_range(0, 29) != 0) text_q.push_back(CHAR_F);
         case ($urandom_range(0, 9))
            0: blocks = 1;
            1: blocks = 2;
            2: blocks = 4;
            default: blocks = 3;
         endcase
         for (i = 0; i < blocks; i++) begin
            if (i > 0 || $urandom_range(0, 4) != 0) begin
               case ($urandom_range(0, 5))
                  0: add_text("  ");
                  1: begin
                     text_q.push_back(8'($urandom_range(0, 255)));
                     text_q.push_back(CHAR_SPACE);
                  end
                  default: text_q.push_back(CHAR_SPACE);
               endcase
            end
            add_number();
            case ($urandom_range(0, 9))
               0: begin
               end
               1: begin
                  text_q.push_back(CHAR_SLASH);
                  add_number();
               end
               2: text_q.push_back(CHAR_SLASH);
               3: begin
                  add_text("//");
                  add_normal_text();
               end
               default: begin
                  text_q.push_back(CHAR_SLASH);
                  add_number();
                  text_q.push_back(CHAR_SLASH);
                  add_normal_text();
               end
            endcase
         end
         // trailing junk or carriage return
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) == 0) text_q.push_back(CHAR_CR);
            else text_q.push_back(8'($urandom_range(0, 255)));
         end
         // cut the line short now and then
         if ($urandom_range(0, 9) == 0 && text_q.size() > 1) begin
            n = $urandom_range(1, text_q.size() - 1);
            while (text_q.size() > n) void'(text_q.pop_back());
         end
      end
   endfunction

   // offer one item, called at a falling edge; bursts with random gaps
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data  <= {c, last};
      do @(posedge clock); while (req_stall !== 1'b0);
      accepted_items++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_line();
      int k;
      for (k = 0; k < text_q.size(); k++) send_char(text_q[k], k == text_q.size() - 1);
   endtask

   task automatic send_string(string s);
      text_q.delete();
      add_text(s);
      send_line();
   endtask

   // stimulus and verdict
   initial begin
      int random_items;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      random_items = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no f on the line, extreme character codes
      text_q.delete();
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      send_line();
      // space before second slash, signed normal, line ends before third block
      send_string("f12/7 9//+8");
      // normal after blanks is read again as the next vertex
      send_string("f1// 5 6");
      // normal text that is not a number
      send_string("f3//x");

      while (random_items < RANDOM_ITEMS) begin
         build_face_line();
         random_items += text_q.size();
         send_line();
      end

      req_valid <= 1'b0;
      while (records_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && records_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold-off to fill the block
   initial begin
      stall_mode_type mode;
      int             seg;
      int             k;
      logic           held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      @(negedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         seg  = $urandom_range(10, 150);
         for (k = 0; k < seg; k++) begin
            if (!held && accepted_items >= HOLD_AFTER) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:  rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ofip_pkg.sv
hw/rtl/ofip_front.sv
hw/rtl/ofip_queue.sv
hw/rtl/ofip_back.sv
hw/rtl/obj_face_index_parser_top.sv
verif/tb_obj_face_index_parser_checker.sv
verif/tb_obj_face_index_parser_top.sv
